>>> rtl/core/crc8rx_pkg.sv
`default_nettype none

package crc8rx_pkg;

    // Field widths fixed by the frame format.
    localparam int BYTE_W  = 8;
    localparam int ANGLE_W = 16;
    localparam int DIV_CNT_W = $clog2(ANGLE_W);

    // CRC-8 generator polynomial x^8 + x^2 + x + 1, MSB first.
    localparam logic [7:0] CRC_POLY = 8'h07;

    // Frame byte positions; zero means no frame in progress.
    localparam int POS_IDLE      = 0;
    localparam int POS_HEADER    = 1;
    localparam int POS_ANGLE_HI  = 2;
    localparam int POS_ANGLE_LO  = 3;
    localparam int POS_SPEED     = 4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_PREAMBLE   = 2'd0;
    localparam logic [1:0] REG_ANGLE_MAX  = 2'd1;
    localparam logic [1:0] REG_ANGLE_MASK = 2'd2;

    // Register reset values.
    localparam logic [7:0]  PREAMBLE_RST   = 8'h00;
    localparam logic [15:0] ANGLE_MAX_RST  = 16'hFFFF;
    localparam logic [15:0] ANGLE_MASK_RST = 16'hFFFF;

    // One decoded frame handed from the front to the back.
    typedef struct packed {
        logic              frame_ok;
        logic [7:0]        header;
        logic [ANGLE_W-1:0] angle;
        logic [7:0]        speed;
    } job_t;

    // Settings used by the back end.
    typedef struct packed {
        logic [ANGLE_W-1:0] angle_max;
        logic [ANGLE_W-1:0] angle_mask;
    } back_cfg_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

    // One byte of CRC-8 update, bitwise MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/crc8rx_front.sv
`default_nettype none

module crc8rx_front #(
    parameter int PAYLOAD_BYTES = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    input  wire logic [7:0]         byte_data,
    input  wire logic               byte_start,
    input  wire logic [7:0]         preamble_value,
    output logic                    job_push,
    output crc8rx_pkg::job_t        job_data
);

    localparam int FRAME_LEN = PAYLOAD_BYTES + 3;
    localparam int POS_W     = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] P_IDLE   = POS_W'(crc8rx_pkg::POS_IDLE);
    localparam logic [POS_W-1:0] P_HEADER = POS_W'(crc8rx_pkg::POS_HEADER);
    localparam logic [POS_W-1:0] P_AHI    = POS_W'(crc8rx_pkg::POS_ANGLE_HI);
    localparam logic [POS_W-1:0] P_ALO    = POS_W'(crc8rx_pkg::POS_ANGLE_LO);
    localparam logic [POS_W-1:0] P_SPEED  = POS_W'(crc8rx_pkg::POS_SPEED);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic             pre_ok_reg, pre_ok_next;
    logic [7:0]       header_reg, header_next;
    logic [7:0]       ahi_reg, ahi_next;
    logic [7:0]       alo_reg, alo_next;
    logic [7:0]       speed_reg, speed_next;

    // Control state: position in the frame, preamble result and running CRC.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg    <= P_IDLE;
            pre_ok_reg <= 1'b0;
            crc_reg    <= 8'h00;
        end
        else begin
            pos_reg    <= pos_next;
            pre_ok_reg <= pre_ok_next;
            crc_reg    <= crc_next;
        end
    end

    // Captured frame fields.
    always_ff @(posedge clk) begin
        header_reg <= header_next;
        ahi_reg    <= ahi_next;
        alo_reg    <= alo_next;
        speed_reg  <= speed_next;
    end

    // Byte classification and CRC accumulation.
    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        pre_ok_next = pre_ok_reg;
        header_next = header_reg;
        ahi_next    = ahi_reg;
        alo_next    = alo_reg;
        speed_next  = speed_reg;
        job_push    = 1'b0;

        job_data.frame_ok = pre_ok_reg && (byte_data == crc_reg);
        job_data.header   = header_reg;
        job_data.angle    = {ahi_reg, alo_reg};
        job_data.speed    = speed_reg;

        if (byte_valid) begin
            if (byte_start) begin
                pre_ok_next = (byte_data == preamble_value);
                crc_next    = crc8rx_pkg::crc8_step(8'h00, byte_data);
                pos_next    = P_HEADER;
            end
            else if (pos_reg == P_IDLE) begin
                // A byte outside a frame is dropped.
                pos_next = P_IDLE;
            end
            else if (pos_reg != LAST_POS) begin
                if (pos_reg == P_HEADER) begin
                    header_next = byte_data;
                end
                if (pos_reg == P_AHI) begin
                    ahi_next = byte_data;
                end
                if (pos_reg == P_ALO) begin
                    alo_next = byte_data;
                end
                if (pos_reg == P_SPEED) begin
                    speed_next = byte_data;
                end
                crc_next = crc8rx_pkg::crc8_step(crc_reg, byte_data);
                pos_next = pos_reg + POS_W'(1);
            end
            else begin
                // CRC byte: hand the frame to the back end.
                job_push = 1'b1;
                pos_next = P_IDLE;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/crc8rx_fifo.sv
`default_nettype none

module crc8rx_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire crc8rx_pkg::job_t  push_data,
    input  wire logic              pop,
    output crc8rx_pkg::job_t       pop_data,
    output logic                   full,
    output logic                   empty
);

    crc8rx_pkg::job_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];
    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);

endmodule

`default_nettype wire

>>> rtl/core/crc8rx_back.sv
`default_nettype none

module crc8rx_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire crc8rx_pkg::back_cfg_t  cfg,
    input  wire logic                   job_empty,
    input  wire crc8rx_pkg::job_t       job_data,
    output logic                        job_pop,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output crc8rx_pkg::job_t            res_data
);

    localparam int AW = crc8rx_pkg::ANGLE_W;
    localparam int CW = crc8rx_pkg::DIV_CNT_W;
    localparam logic [CW-1:0] LAST_STEP = CW'(AW - 1);

    crc8rx_pkg::back_state_t state_reg, state_next;
    crc8rx_pkg::job_t        job_reg, job_next;
    crc8rx_pkg::job_t        out_reg, out_next;
    logic [AW-1:0]           rem_reg, rem_next;
    logic [AW-1:0]           dvd_reg, dvd_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [AW:0]             shifted;
    logic [AW:0]             diff;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= crc8rx_pkg::BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        job_reg <= job_next;
        out_reg <= out_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    // One restoring division step per cycle, then mask into the output register.
    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        out_next       = out_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        job_pop        = 1'b0;

        shifted = {rem_reg, dvd_reg[AW-1]};
        diff    = shifted - {1'b0, cfg.angle_max};

        if (out_valid_reg && res_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            crc8rx_pkg::BK_IDLE: begin
                if (!job_empty) begin
                    job_pop  = 1'b1;
                    job_next = job_data;
                    cnt_next = '0;
                    if (cfg.angle_max == '0) begin
                        // Zero modulus leaves the angle unreduced.
                        rem_next   = job_data.angle;
                        state_next = crc8rx_pkg::BK_DONE;
                    end
                    else begin
                        rem_next   = '0;
                        dvd_next   = job_data.angle;
                        state_next = crc8rx_pkg::BK_DIV;
                    end
                end
            end
            crc8rx_pkg::BK_DIV: begin
                rem_next = diff[AW] ? shifted[AW-1:0] : diff[AW-1:0];
                dvd_next = {dvd_reg[AW-2:0], 1'b0};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST_STEP) begin
                    state_next = crc8rx_pkg::BK_DONE;
                end
            end
            crc8rx_pkg::BK_DONE: begin
                if (!out_valid_reg || res_ready) begin
                    out_next       = job_reg;
                    out_next.angle = rem_reg & cfg.angle_mask;
                    out_valid_next = 1'b1;
                    state_next     = crc8rx_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = crc8rx_pkg::BK_IDLE;
            end
        endcase
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/crc8_request_frame_receiver.sv
// Accepts one frame byte per cycle whenever the two-entry frame queue has room.
// After the CRC byte transfer, the frame is queued; the back end dequeues it, runs
// 16 restoring-division steps for the modulo (none for zero modulus), then masks.
// The division sequencer takes one frame at a time; later frames wait in the queue.
// Reset (rst_n low, asynchronous) clears frame tracking, the queue and the output,
// and returns the registers to preamble 0, angle_max 65535, angle_mask 65535.
`default_nettype none

module crc8_request_frame_receiver #(
    parameter int PAYLOAD_BYTES = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Byte stream in.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] frame_start
    // Frame results out.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [3:0] node_address, [7:4] request_code,
                                        // [23:8] reduced angle, [31:24] speed_value
    output logic             m_tuser,   // [0] frame_ok
    // Configuration.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]  preamble_reg;
    logic [15:0] angle_max_reg;
    logic [15:0] angle_mask_reg;
    logic        cfg_wr;

    logic                  job_push;
    logic                  job_pop;
    logic                  job_full;
    logic                  job_empty;
    crc8rx_pkg::job_t      front_job;
    crc8rx_pkg::job_t      queue_job;
    crc8rx_pkg::job_t      res_job;
    crc8rx_pkg::back_cfg_t back_cfg;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            preamble_reg   <= crc8rx_pkg::PREAMBLE_RST;
            angle_max_reg  <= crc8rx_pkg::ANGLE_MAX_RST;
            angle_mask_reg <= crc8rx_pkg::ANGLE_MASK_RST;
        end
        else if (cfg_wr) begin
            case (paddr[3:2])
                crc8rx_pkg::REG_PREAMBLE:   preamble_reg   <= pwdata[7:0];
                crc8rx_pkg::REG_ANGLE_MAX:  angle_max_reg  <= pwdata[15:0];
                crc8rx_pkg::REG_ANGLE_MASK: angle_mask_reg <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (paddr[3:2])
            crc8rx_pkg::REG_PREAMBLE:   prdata = {24'd0, preamble_reg};
            crc8rx_pkg::REG_ANGLE_MAX:  prdata = {16'd0, angle_max_reg};
            crc8rx_pkg::REG_ANGLE_MASK: prdata = {16'd0, angle_mask_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign back_cfg.angle_max  = angle_max_reg;
    assign back_cfg.angle_mask = angle_mask_reg;

    // Byte intake stalls only while the frame queue is full.
    assign s_tready = !job_full;

    crc8rx_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (s_tvalid && s_tready),
        .byte_data      (s_tdata),
        .byte_start     (s_tuser),
        .preamble_value (preamble_reg),
        .job_push       (job_push),
        .job_data       (front_job)
    );

    crc8rx_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (front_job),
        .pop       (job_pop),
        .pop_data  (queue_job),
        .full      (job_full),
        .empty     (job_empty)
    );

    crc8rx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (back_cfg),
        .job_empty (job_empty),
        .job_data  (queue_job),
        .job_pop   (job_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (res_job)
    );

    // Result packing.
    assign m_tdata = {res_job.speed, res_job.angle, res_job.header[3:0], res_job.header[7:4]};
    assign m_tuser = res_job.frame_ok;

endmodule

`default_nettype wire

>>> rtl/core/crc8rx_checker.sv
`default_nettype none

module crc8rx_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [3:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // An accepted byte carries known data and start flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !$isunknown({s_tdata, s_tuser}))
        else $error("byte transfer with unknown payload");

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // A preamble write reads back on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[3:2] == crc8rx_pkg::REG_PREAMBLE)
        ##1 (paddr[3:2] == crc8rx_pkg::REG_PREAMBLE)
        |-> prdata == {24'd0, $past(pwdata[7:0])})
        else $error("preamble register read back mismatch");

    // Unused register space reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        paddr[3:2] == 2'd3 |-> prdata == 32'd0)
        else $error("unmapped register returned data");

endmodule

bind crc8_request_frame_receiver crc8rx_checker u_crc8rx_checker (.*);

`default_nettype wire

>>> tb/sv/crc8rx_tb_pkg.sv
`default_nettype none

package crc8rx_tb_pkg;

    // Byte addresses of the configuration registers; the spare one has no register behind it.
    localparam logic [3:0] ADDR_PREAMBLE   = {crc8rx_pkg::REG_PREAMBLE, 2'b00};
    localparam logic [3:0] ADDR_ANGLE_MAX  = {crc8rx_pkg::REG_ANGLE_MAX, 2'b00};
    localparam logic [3:0] ADDR_ANGLE_MASK = {crc8rx_pkg::REG_ANGLE_MASK, 2'b00};
    localparam logic [3:0] ADDR_SPARE      = 4'hC;

    // One decoded request frame as it leaves the receiver.
    typedef struct packed {
        logic        ok;
        logic [3:0]  node;
        logic [3:0]  code;
        logic [15:0] angle;
        logic [7:0]  speed;
    } frame_result_t;

    // CRC-8 update, one data bit at a time from the MSB down.
    function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            if (r[7] ^ data[i]) begin
                r = {r[6:0], 1'b0} ^ crc8rx_pkg::CRC_POLY;
            end
            else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> tb/sv/crc8rx_frame_checker.sv
`default_nettype none

module crc8rx_frame_checker #(
    parameter int PAYLOAD_BYTES = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               pending,
    output int               results_seen,
    output int               valid_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    // Position of the CRC byte within a frame.
    localparam logic [3:0] CRC_POS = 4'(PAYLOAD_BYTES + 2);

    // Register copies.
    logic [7:0]  cfg_pre;
    logic [15:0] cfg_max;
    logic [15:0] cfg_mask;

    // Frame tracking.
    logic [3:0]  byte_pos;
    logic [7:0]  crc_acc;
    logic        pre_hit;
    logic [7:0]  hdr_q;
    logic [7:0]  ang_hi_q;
    logic [7:0]  ang_lo_q;
    logic [7:0]  spd_q;

    crc8rx_tb_pkg::frame_result_t awaited[$];
    crc8rx_tb_pkg::frame_result_t got;
    crc8rx_tb_pkg::frame_result_t want;
    int fails = 0;
    int n_results = 0;
    int n_valid = 0;

    task automatic flag(input string what, input logic [31:0] want_v, input logic [31:0] got_v);
        if (fails < 10) begin
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want_v, got_v);
        end
        fails++;
    endtask

    // Advance the frame tracker by one byte; the CRC byte yields one expected result.
    task automatic take_byte(input logic [7:0] b, input logic start);
        logic [15:0] ang;
        crc8rx_tb_pkg::frame_result_t r;
        if (start) begin
            pre_hit  = (b == cfg_pre);
            crc_acc  = crc8rx_tb_pkg::crc8_update(8'h00, b);
            byte_pos = 4'd1;
        end
        else if (byte_pos != 4'd0) begin
            if (byte_pos < CRC_POS) begin
                case (int'(byte_pos))
                    crc8rx_pkg::POS_HEADER:   hdr_q    = b;
                    crc8rx_pkg::POS_ANGLE_HI: ang_hi_q = b;
                    crc8rx_pkg::POS_ANGLE_LO: ang_lo_q = b;
                    crc8rx_pkg::POS_SPEED:    spd_q    = b;
                    default: ;
                endcase
                crc_acc  = crc8rx_tb_pkg::crc8_update(crc_acc, b);
                byte_pos = byte_pos + 4'd1;
            end
            else begin
                // A zero modulus leaves the angle unreduced.
                ang = {ang_hi_q, ang_lo_q};
                if (cfg_max != 16'd0) begin
                    ang = ang % cfg_max;
                end
                r.ok    = pre_hit && (b == crc_acc);
                r.node  = hdr_q[7:4];
                r.code  = hdr_q[3:0];
                r.angle = ang & cfg_mask;
                r.speed = spd_q;
                awaited.push_back(r);
                byte_pos = 4'd0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_pre  = crc8rx_pkg::PREAMBLE_RST;
            cfg_max  = crc8rx_pkg::ANGLE_MAX_RST;
            cfg_mask = crc8rx_pkg::ANGLE_MASK_RST;
            byte_pos = 4'd0;
            crc_acc  = 8'h00;
            pre_hit  = 1'b0;
            hdr_q    = 8'h00;
            ang_hi_q = 8'h00;
            ang_lo_q = 8'h00;
            spd_q    = 8'h00;
            awaited.delete();
        end
        else begin
            // Register writes update the copies; reads are compared against them.
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr)
                        crc8rx_tb_pkg::ADDR_PREAMBLE:   cfg_pre  = pwdata[7:0];
                        crc8rx_tb_pkg::ADDR_ANGLE_MAX:  cfg_max  = pwdata[15:0];
                        crc8rx_tb_pkg::ADDR_ANGLE_MASK: cfg_mask = pwdata[15:0];
                        default: ;
                    endcase
                end
                else begin
                    case (paddr)
                        crc8rx_tb_pkg::ADDR_PREAMBLE:
                            if (prdata !== {24'h0, cfg_pre}) begin
                                flag("preamble_value read", {24'h0, cfg_pre}, prdata);
                            end
                        crc8rx_tb_pkg::ADDR_ANGLE_MAX:
                            if (prdata !== {16'h0, cfg_max}) begin
                                flag("angle_max read", {16'h0, cfg_max}, prdata);
                            end
                        crc8rx_tb_pkg::ADDR_ANGLE_MASK:
                            if (prdata !== {16'h0, cfg_mask}) begin
                                flag("angle_mask read", {16'h0, cfg_mask}, prdata);
                            end
                        default: ;
                    endcase
                end
            end

            // Result transfers are matched against the oldest expectation first.
            if (m_tvalid && m_tready) begin
                got.ok    = m_tuser;
                got.node  = m_tdata[3:0];
                got.code  = m_tdata[7:4];
                got.angle = m_tdata[23:8];
                got.speed = m_tdata[31:24];
                n_results++;
                if (got.ok === 1'b1) begin
                    n_valid++;
                end
                if (awaited.size() == 0) begin
                    flag("result with nothing expected (tdata)", 32'h0, m_tdata);
                end
                else begin
                    want = awaited.pop_front();
                    if (got.ok !== want.ok) begin
                        flag("frame_ok", 32'(want.ok), 32'(got.ok));
                    end
                    if (got.node !== want.node) begin
                        flag("node_address", 32'(want.node), 32'(got.node));
                    end
                    if (got.code !== want.code) begin
                        flag("request_code", 32'(want.code), 32'(got.code));
                    end
                    if (got.angle !== want.angle) begin
                        flag("reduced angle", 32'(want.angle), 32'(got.angle));
                    end
                    if (got.speed !== want.speed) begin
                        flag("speed_value", 32'(want.speed), 32'(got.speed));
                    end
                end
            end

            // Byte transfers feed the frame tracker.
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata, s_tuser);
            end
        end
        fail_count   <= fails;
        pending      <= awaited.size();
        results_seen <= n_results;
        valid_seen   <= n_valid;
    end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD_BYTES = 3;
    localparam int FRAME_LEN     = PAYLOAD_BYTES + 3;
    localparam int PHASE_BYTES   = 160;
    // Results trail the CRC byte through the queue and divider; two frames can be queued.
    localparam int DRAIN_CYCLES  = 64;
    // Cycles without any transfer before the run is declared hung.
    localparam int QUIET_LIMIT   = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int frames_pending;
    int results_seen;
    int valid_seen;

    bit          src_gaps = 1'b1;
    bit          snk_gaps = 1'b1;
    int          byte_count = 0;
    int          quiet_cycles = 0;
    logic [7:0]  cur_pre;
    logic [15:0] cur_max;

    crc8_request_frame_receiver #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    crc8rx_frame_checker #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) chk (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .fail_count(fail_count),
        .pending(frames_pending),
        .results_seen(results_seen),
        .valid_seen(valid_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hang detection: any transfer on any port restarts the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: ready with random stall bursts while they are enabled.
    initial
    begin
        forever
        begin
            if (snk_gaps && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // One register access: setup phase, access phase held until pready, then idle.
    task automatic apb_access(input bit wr, input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_all_regs();
        apb_access(1'b0, crc8rx_tb_pkg::ADDR_PREAMBLE, 32'h0);
        apb_access(1'b0, crc8rx_tb_pkg::ADDR_ANGLE_MAX, 32'h0);
        apb_access(1'b0, crc8rx_tb_pkg::ADDR_ANGLE_MASK, 32'h0);
    endtask

    // Writes all registers, pokes the unused address, and reads the three registers back.
    task automatic set_config(input logic [7:0] pre, input logic [15:0] amax,
                              input logic [15:0] amask);
        apb_access(1'b1, crc8rx_tb_pkg::ADDR_PREAMBLE, {24'h0, pre});
        apb_access(1'b1, crc8rx_tb_pkg::ADDR_ANGLE_MAX, {16'h0, amax});
        apb_access(1'b1, crc8rx_tb_pkg::ADDR_ANGLE_MASK, {16'h0, amask});
        apb_access(1'b1, crc8rx_tb_pkg::ADDR_SPARE, $urandom);
        read_all_regs();
        cur_pre = pre;
        cur_max = amax;
    endtask

    // One byte transfer, optionally preceded by an idle burst.
    task automatic send_byte(input logic [7:0] b, input logic start);
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        byte_count++;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Builds a frame with its CRC (xored with crc_flip) and sends it, or its first cut bytes.
    task automatic send_frame(input logic [7:0] pre, input logic [7:0] hdr,
                              input logic [15:0] ang, input logic [7:0] spd,
                              input logic [7:0] crc_flip, input int cut);
        logic [7:0] fb[$];
        logic [7:0] crc;
        int count;
        fb.push_back(pre);
        fb.push_back(hdr);
        fb.push_back(ang[15:8]);
        fb.push_back(ang[7:0]);
        fb.push_back(spd);
        repeat (PAYLOAD_BYTES - 3) fb.push_back(8'($urandom));
        crc = 8'h00;
        foreach (fb[i])
        begin
            crc = crc8rx_tb_pkg::crc8_update(crc, fb[i]);
        end
        fb.push_back(crc ^ crc_flip);
        count = (cut > 0) ? cut : fb.size();
        for (int i = 0; i < count; i++)
        begin
            send_byte(fb[i], i == 0);
        end
    endtask

    // Mostly well-formed frames, with bad CRCs, wrong preambles, cut frames and stray bytes.
    task automatic run_random(input int n_bytes);
        int done_bytes;
        int pick;
        int cut;
        logic [7:0] pre;
        logic [7:0] flip;
        logic [15:0] ang;
        done_bytes = 0;
        while (done_bytes < n_bytes)
        begin
            pick = $urandom_range(0, 99);
            pre  = cur_pre;
            flip = 8'h00;
            ang  = 16'($urandom);
            case ($urandom_range(0, 7))
                0: ang = 16'h0000;
                1: ang = 16'hFFFF;
                2: ang = cur_max;
                3: ang = cur_max - 16'd1;
                default: ;
            endcase
            if (pick < 90)
            begin
                if (pick >= 80)
                begin
                    pre = cur_pre ^ 8'($urandom_range(1, 255));
                end
                else if (pick >= 70)
                begin
                    flip = 8'($urandom_range(1, 255));
                end
                send_frame(pre, 8'($urandom), ang, 8'($urandom), flip, 0);
                done_bytes += FRAME_LEN;
            end
            else if (pick < 95)
            begin
                cut = $urandom_range(1, FRAME_LEN - 1);
                send_frame(pre, 8'($urandom), ang, 8'($urandom), 8'h00, cut);
                done_bytes += cut;
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            end
        end
    endtask

    // Stops the byte stream and waits until every expected result is in and the block is quiet.
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (frames_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: registers read back, stray bytes, extreme, cut and bad-CRC/preamble frames.
        cur_pre = crc8rx_pkg::PREAMBLE_RST;
        cur_max = crc8rx_pkg::ANGLE_MAX_RST;
        read_all_regs();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_frame(8'h00, 8'hFF, 16'hFFFF, 8'hFF, 8'h00, 0);
        send_frame(8'h00, 8'hA5, 16'h1234, 8'h55, 8'h00, 3);
        send_frame(8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 0);
        send_frame(8'h5A, 8'h3C, 16'h8000, 8'h81, 8'h01, 0);
        finish_phase();

        // Unit modulus: every angle reduces to zero.
        set_config(8'hFF, 16'd1, 16'hFFFF);
        run_random(PHASE_BYTES);
        finish_phase();

        // Zero modulus leaves the angle unreduced; source gaps only.
        snk_gaps = 1'b0;
        set_config(8'hA5, 16'd0, 16'hFFFF);
        run_random(PHASE_BYTES);
        finish_phase();

        // Empty mask; result stalls only.
        src_gaps = 1'b0;
        snk_gaps = 1'b1;
        set_config(8'($urandom), 16'($urandom_range(1, 65535)), 16'h0000);
        run_random(PHASE_BYTES);
        finish_phase();

        // Random settings with gaps on both sides.
        src_gaps = 1'b1;
        set_config(8'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom));
        run_random(PHASE_BYTES);
        finish_phase();

        // Last stretch at full rate with no gaps.
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
        set_config(8'h00, 16'hFFFF, 16'hFFF0);
        run_random(PHASE_BYTES);
        finish_phase();

        $display("Sent %0d bytes over six register settings; checked %0d frame results, %0d valid.",
                 byte_count, results_seen, valid_seen);
        $display("Settings covered unit, zero and full modulus, empty and partial masks.");
        if (fail_count == 0 && frames_pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
